// ===== design/adcbm_pkg.sv =====
`timescale 1ns / 1ps

package adcbm_pkg;

  localparam int GAMMA_ENTRIES_DEF = 16;

  // config port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BL_RAW_LOW    = 3'd0,
    CFG_BL_RAW_HIGH   = 3'd1,
    CFG_LOW_BAT_LEVEL = 3'd2,
    CFG_MEAS_DELAY    = 3'd3,
    CFG_BAT_ICON_EN   = 3'd4,
    CFG_BL_EN         = 3'd5
  } cfg_reg_t;

  // register reset values
  localparam logic [15:0] BL_RAW_LOW_RST    = 16'd4096;
  localparam logic [15:0] BL_RAW_HIGH_RST   = 16'd61440;
  localparam logic [15:0] LOW_BAT_LEVEL_RST = 16'd32768;
  localparam logic [7:0]  MEAS_DELAY_RST    = 8'd10;

  localparam logic [15:0] FILT_BAT_RST = 16'hFFFF;
  localparam logic [15:0] FILT_BRI_RST = 16'h0000;

  localparam logic [7:0]  DELAY_MIN   = 8'd2;
  localparam logic [15:0] BLINK_MASK  = 16'h01FF;
  localparam logic [15:0] BLINK_PHASE = 16'h0200;
  localparam logic [5:0]  IDX_NONE    = 6'd63;

  localparam logic CH_BAT = 1'b0;
  localparam logic CH_BRI = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STEP,
    ST_CHECK,
    ST_DIV,
    ST_OUT
  } state_t;

endpackage

// ===== design/adcbm_div.sv =====
`timescale 1ns / 1ps

// restoring divider, one quotient bit per cycle, 8-bit divisor
module adcbm_div #(
  parameter int DVD_W = 12
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [7:0]       divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);
  import adcbm_pkg::*;

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] work_r, work_nxt;
  logic [7:0]       rem_r, rem_nxt;
  logic [7:0]       dsr_r, dsr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             done_r, done_nxt;
  logic [8:0]       trial;
  logic             qbit;

  assign trial = {rem_r, work_r[DVD_W-1]};
  assign qbit  = (trial >= {1'b0, dsr_r});

  always_comb begin
    work_nxt = work_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      work_nxt = dividend;
      rem_nxt  = 8'd0;
      dsr_nxt  = divisor;
      cnt_nxt  = CNT_W'(DVD_W);
    end else if (cnt_r != '0) begin
      rem_nxt  = qbit ? 8'(trial - {1'b0, dsr_r}) : trial[7:0];
      work_nxt = {work_r[DVD_W-2:0], qbit};
      cnt_nxt  = cnt_r - CNT_W'(1);
      done_nxt = (cnt_r == CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    work_r <= work_nxt;
    rem_r  <= rem_nxt;
    dsr_r  <= dsr_nxt;
  end

  assign done     = done_r;
  assign quotient = work_r;

endmodule

// ===== design/adc_backlight_battery_monitor_top.sv =====
`timescale 1ns / 1ps

// ADC sequencer for a battery monitor and a backlight brightness knob. Each input item is one
// millisecond tick (the ADC done flag and the sample read that tick); each tick gives exactly
// one result item: the ADC control write for the tick, the current gamma index for the
// backlight PWM, and the low-battery icon state. Ticks count down a measurement delay, then
// power the ADC up, start it, and wait for the done flag. A sample is smoothed per channel
// (f -= f/4, f += v/4); battery samples latch a low-battery flag, brightness samples pick a new
// gamma index once the filtered value has moved by 0x100 or more. Between the rails the index
// comes from a restoring divider, one quotient bit per cycle. Timing: one item at a time;
// in_ready is high only while idle. A tick passes ST_STEP and ST_OUT, a sample also ST_CHECK,
// and a new index also ST_DIV for the SPAN_W-bit division (SPAN_W = 12 for 16 gamma entries);
// the divider is the long pole. A result is held until out_ready. Config writes apply at once
// and are meant for idle periods; a new meas_delay takes effect at the next reload.
module adc_backlight_battery_monitor_top #(
  parameter int GAMMA_ENTRIES = adcbm_pkg::GAMMA_ENTRIES_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,

  input  logic                               cfg_we,
  input  logic [adcbm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [adcbm_pkg::CFG_DATA_W-1:0]   cfg_data,

  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_adc_done,
  input  logic [15:0]                        in_adc_sample,

  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_adc_ctrl_write,
  output logic                               out_adc_power,
  output logic                               out_adc_start,
  output logic                               out_adc_channel_sel,
  output logic [5:0]                         out_backlight_index,
  output logic                               out_backlight_update,
  output logic                               out_battery_update,
  output logic                               out_battery_show,
  output logic                               out_low_battery
);
  import adcbm_pkg::*;

  // span = ((v - low) >> 8) * (GAMMA_ENTRIES - 2) fits in 8 + clog2(GAMMA_ENTRIES - 1) bits
  localparam int          SPAN_W  = 8 + $clog2(GAMMA_ENTRIES - 1);
  localparam logic [5:0]  IDX_MAX = 6'(GAMMA_ENTRIES - 1);
  localparam logic [SPAN_W-1:0] Q_MAX = SPAN_W'(GAMMA_ENTRIES - 2);

  // config registers
  logic [15:0] bl_raw_low_r, bl_raw_high_r, low_bat_level_r;
  logic [7:0]  meas_delay_r;
  logic        bat_icon_en_r, bl_en_r;

  // block state
  state_t      state_r, state_nxt;
  logic [15:0] tick_r, tick_nxt;
  logic [7:0]  delay_r, delay_nxt;
  logic [15:0] filt_bat_r, filt_bat_nxt;
  logic [15:0] filt_bri_r, filt_bri_nxt;
  logic        chan_now_r, chan_now_nxt;
  logic [15:0] last_lvl_r, last_lvl_nxt;
  logic [5:0]  idx_r, idx_nxt;
  logic        low_bat_r, low_bat_nxt;

  // per-item working registers
  logic        done_in_r, done_in_nxt;
  logic [15:0] sample_r, sample_nxt;
  logic [15:0] f_r, f_nxt;
  logic        ch_r, ch_nxt;
  logic [5:0]  old_idx_r, old_idx_nxt;
  logic        wr_r, wr_nxt;
  logic        pwr_r, pwr_nxt;
  logic        start_r, start_nxt;
  logic        sel_r, sel_nxt;

  // datapath terms
  logic [15:0] f_cur, f_new;
  logic [15:0] lvl_diff;
  logic [15:0] knob_off, knob_span;
  logic [SPAN_W-1:0] span;
  logic [7:0]  divisor;
  logic        div_start;
  logic        div_done;
  logic [SPAN_W-1:0] quot;
  logic        blink_tick;

  assign f_cur = (chan_now_r == CH_BRI) ? filt_bri_r : filt_bat_r;
  assign f_new = 16'(f_cur - {2'b00, f_cur[15:2]} + {2'b00, sample_r[15:2]});

  assign lvl_diff  = (last_lvl_r < f_r) ? 16'(f_r - last_lvl_r) : 16'(last_lvl_r - f_r);
  assign knob_off  = 16'(f_r - bl_raw_low_r);
  assign knob_span = 16'(bl_raw_high_r - bl_raw_low_r);
  assign span      = SPAN_W'(knob_off[15:8]) * SPAN_W'(GAMMA_ENTRIES - 2);
  assign divisor   = (knob_span[15:8] == 8'd0) ? 8'd1 : knob_span[15:8];

  adcbm_div #(
    .DVD_W (SPAN_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (span),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (quot)
  );

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bl_raw_low_r    <= BL_RAW_LOW_RST;
      bl_raw_high_r   <= BL_RAW_HIGH_RST;
      low_bat_level_r <= LOW_BAT_LEVEL_RST;
      meas_delay_r    <= MEAS_DELAY_RST;
      bat_icon_en_r   <= 1'b1;
      bl_en_r         <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_BL_RAW_LOW:    bl_raw_low_r    <= cfg_data;
        CFG_BL_RAW_HIGH:   bl_raw_high_r   <= cfg_data;
        CFG_LOW_BAT_LEVEL: low_bat_level_r <= cfg_data;
        CFG_MEAS_DELAY:    meas_delay_r    <= cfg_data[7:0];
        CFG_BAT_ICON_EN:   bat_icon_en_r   <= cfg_data[0];
        CFG_BL_EN:         bl_en_r         <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    tick_nxt     = tick_r;
    delay_nxt    = delay_r;
    filt_bat_nxt = filt_bat_r;
    filt_bri_nxt = filt_bri_r;
    chan_now_nxt = chan_now_r;
    last_lvl_nxt = last_lvl_r;
    idx_nxt      = idx_r;
    low_bat_nxt  = low_bat_r;
    done_in_nxt  = done_in_r;
    sample_nxt   = sample_r;
    f_nxt        = f_r;
    ch_nxt       = ch_r;
    old_idx_nxt  = old_idx_r;
    wr_nxt       = wr_r;
    pwr_nxt      = pwr_r;
    start_nxt    = start_r;
    sel_nxt      = sel_r;
    div_start    = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          done_in_nxt = in_adc_done;
          sample_nxt  = in_adc_sample;
          old_idx_nxt = idx_r;
          wr_nxt      = 1'b0;
          pwr_nxt     = 1'b0;
          start_nxt   = 1'b0;
          sel_nxt     = 1'b0;
          state_nxt   = ST_STEP;
        end
      end

      ST_STEP: begin
        state_nxt = ST_OUT;
        if (delay_r >= DELAY_MIN) begin
          delay_nxt = 8'(delay_r - 8'd1);
          if (delay_r == DELAY_MIN) begin
            // power-up write
            wr_nxt  = 1'b1;
            pwr_nxt = 1'b1;
            sel_nxt = chan_now_r;
          end
        end else if (delay_r == 8'd1) begin
          // start conversion
          wr_nxt    = 1'b1;
          pwr_nxt   = 1'b1;
          start_nxt = 1'b1;
          sel_nxt   = chan_now_r;
          delay_nxt = 8'd0;
        end else if (done_in_r) begin
          // take sample, shut the ADC down
          f_nxt  = f_new;
          ch_nxt = chan_now_r;
          if (chan_now_r == CH_BRI) begin
            filt_bri_nxt = f_new;
          end else begin
            filt_bat_nxt = f_new;
          end
          wr_nxt       = 1'b1;
          delay_nxt    = (meas_delay_r < DELAY_MIN) ? DELAY_MIN : meas_delay_r;
          chan_now_nxt = bl_en_r ? ~chan_now_r : CH_BAT;
          state_nxt    = ST_CHECK;
        end
      end

      ST_CHECK: begin
        state_nxt = ST_OUT;
        if (ch_r == CH_BRI) begin
          if (lvl_diff[15:8] != 8'd0) begin
            last_lvl_nxt = f_r;
            if (f_r <= bl_raw_low_r) begin
              idx_nxt = 6'd0;
            end else if (f_r >= bl_raw_high_r) begin
              idx_nxt = IDX_MAX;
            end else begin
              div_start = 1'b1;
              state_nxt = ST_DIV;
            end
          end
        end else if (f_r <= low_bat_level_r) begin
          low_bat_nxt = 1'b1;
        end
      end

      ST_DIV: begin
        if (div_done) begin
          idx_nxt   = (quot > Q_MAX) ? IDX_MAX : 6'(6'(quot) + 6'd1);
          state_nxt = ST_OUT;
        end
      end

      ST_OUT: begin
        if (out_ready) begin
          tick_nxt  = 16'(tick_r + 16'd1);
          state_nxt = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      tick_r     <= 16'd0;
      delay_r    <= 8'(MEAS_DELAY_RST - 8'd1);
      filt_bat_r <= FILT_BAT_RST;
      filt_bri_r <= FILT_BRI_RST;
      chan_now_r <= CH_BAT;
      last_lvl_r <= 16'd0;
      idx_r      <= IDX_NONE;
      low_bat_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      tick_r     <= tick_nxt;
      delay_r    <= delay_nxt;
      filt_bat_r <= filt_bat_nxt;
      filt_bri_r <= filt_bri_nxt;
      chan_now_r <= chan_now_nxt;
      last_lvl_r <= last_lvl_nxt;
      idx_r      <= idx_nxt;
      low_bat_r  <= low_bat_nxt;
    end
    done_in_r <= done_in_nxt;
    sample_r  <= sample_nxt;
    f_r       <= f_nxt;
    ch_r      <= ch_nxt;
    old_idx_r <= old_idx_nxt;
    wr_r      <= wr_nxt;
    pwr_r     <= pwr_nxt;
    start_r   <= start_nxt;
    sel_r     <= sel_nxt;
  end

  // icon state goes out every 512 ticks while low battery is latched and the icon is enabled
  assign blink_tick = low_bat_r && bat_icon_en_r && ((tick_r & BLINK_MASK) == 16'd0);

  assign in_ready             = (state_r == ST_IDLE);
  assign out_valid            = (state_r == ST_OUT);
  assign out_adc_ctrl_write   = wr_r;
  assign out_adc_power        = pwr_r;
  assign out_adc_start        = start_r;
  assign out_adc_channel_sel  = sel_r;
  assign out_backlight_index  = idx_r;
  assign out_backlight_update = (idx_r != old_idx_r);
  assign out_battery_update   = blink_tick;
  assign out_battery_show     = blink_tick && ((tick_r & BLINK_PHASE) == 16'd0);
  assign out_low_battery      = low_bat_r;

endmodule

// ===== sim/tb_adc_backlight_battery_monitor_top.sv =====
`timescale 1ns / 1ps

module tb_adc_backlight_battery_monitor_top;
  import adcbm_pkg::*;

  localparam int          GAMMA_N       = GAMMA_ENTRIES_DEF;
  localparam logic [15:0] LEVEL_STEP    = 16'h0100;  // knob move needed to re-pick the index
  localparam int          SETTLE_CYCLES = 32;        // > worst tick latency (the divider path)

  // one tick as driven on the input channel
  typedef struct packed {
    logic        done;
    logic [15:0] sample;
  } tick_in_t;

  // one result item, in port order
  typedef struct packed {
    logic       wr;
    logic       pwr;
    logic       start;
    logic       chan;
    logic [5:0] idx;
    logic       bl_upd;
    logic       bat_upd;
    logic       bat_show;
    logic       low_bat;
  } adc_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_adc_done = 1'b0;
  logic [15:0] in_adc_sample = '0;

  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       out_adc_ctrl_write;
  logic       out_adc_power;
  logic       out_adc_start;
  logic       out_adc_channel_sel;
  logic [5:0] out_backlight_index;
  logic       out_backlight_update;
  logic       out_battery_update;
  logic       out_battery_show;
  logic       out_low_battery;

  adc_backlight_battery_monitor_top u_top (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_adc_done          (in_adc_done),
    .in_adc_sample        (in_adc_sample),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_adc_ctrl_write   (out_adc_ctrl_write),
    .out_adc_power        (out_adc_power),
    .out_adc_start        (out_adc_start),
    .out_adc_channel_sel  (out_adc_channel_sel),
    .out_backlight_index  (out_backlight_index),
    .out_backlight_update (out_backlight_update),
    .out_battery_update   (out_battery_update),
    .out_battery_show     (out_battery_show),
    .out_low_battery      (out_low_battery)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------------------
  // Sequencer model: register copies and state, advanced once per accepted tick
  // ---------------------------------------------------------------------------------------
  logic [15:0] reg_bl_lo;
  logic [15:0] reg_bl_hi;
  logic [15:0] reg_low_bat;
  logic [7:0]  reg_delay;
  logic        reg_icon_en;
  logic        reg_bl_en;

  logic [15:0] mdl_tick;
  logic [7:0]  mdl_delay;
  logic [15:0] mdl_filt [2];
  logic        mdl_chan;
  logic [15:0] mdl_applied;   // knob level the current index was picked from
  logic [5:0]  mdl_index;
  logic        mdl_lowbat;

  tick_in_t    pending_ticks[$];     // stimulus not yet on the bus
  adc_result_t expected_results[$];  // predicted results awaiting the output channel
  tick_in_t    cur_tick;

  int n_queued  = 0;
  int n_checked = 0;
  int n_errors  = 0;
  int idle_pct  = 0;   // sender gap probability, percent
  int stall_pct = 0;   // receiver stall probability, percent

  function automatic void reset_model();
    reg_bl_lo   = BL_RAW_LOW_RST;
    reg_bl_hi   = BL_RAW_HIGH_RST;
    reg_low_bat = LOW_BAT_LEVEL_RST;
    reg_delay   = MEAS_DELAY_RST;
    reg_icon_en = 1'b1;
    reg_bl_en   = 1'b1;
    mdl_tick    = '0;
    mdl_delay   = MEAS_DELAY_RST - 8'd1;
    mdl_filt[CH_BAT] = FILT_BAT_RST;
    mdl_filt[CH_BRI] = FILT_BRI_RST;
    mdl_chan    = CH_BAT;
    mdl_applied = '0;
    mdl_index   = IDX_NONE;
    mdl_lowbat  = 1'b0;
  endfunction

  // Gamma index for a filtered knob level; clamps at both ends, divisor forced >= 1.
  function automatic logic [5:0] gamma_index_for(logic [15:0] lvl);
    logic [15:0] above;
    logic [15:0] span;
    int unsigned num;
    int unsigned den;
    int unsigned q;
    if (lvl <= reg_bl_lo) return 6'd0;
    if (lvl >= reg_bl_hi) return 6'(GAMMA_N - 1);
    above = lvl - reg_bl_lo;
    span  = reg_bl_hi - reg_bl_lo;
    num   = int'(above >> 8) * (GAMMA_N - 2);
    den   = int'(span >> 8);
    if (den < 1) den = 1;
    q = 1 + num / den;
    if (q > GAMMA_N - 1) q = GAMMA_N - 1;
    return 6'(q);
  endfunction

  // One millisecond tick: countdown, power-up, start, or wait for done and take the sample.
  function automatic adc_result_t advance_tick(tick_in_t t);
    adc_result_t r;
    logic [5:0]  prev_idx;
    logic [15:0] f;
    logic [15:0] lvl_gap;
    logic        ch;
    r = '0;
    prev_idx = mdl_index;
    if (mdl_delay >= DELAY_MIN) begin
      mdl_delay = mdl_delay - 8'd1;
      if (mdl_delay == 8'd1) begin
        r.wr   = 1'b1;
        r.pwr  = 1'b1;
        r.chan = mdl_chan;
      end
    end else if (mdl_delay == 8'd1) begin
      r.wr    = 1'b1;
      r.pwr   = 1'b1;
      r.start = 1'b1;
      r.chan  = mdl_chan;
      mdl_delay = '0;
    end else if (t.done) begin
      ch = mdl_chan;
      f  = mdl_filt[ch];
      f  = f - (f >> 2);
      f  = f + (t.sample >> 2);
      mdl_filt[ch] = f;
      if (ch == CH_BRI) begin
        lvl_gap = (mdl_applied < f) ? f - mdl_applied : mdl_applied - f;
        if (lvl_gap >= LEVEL_STEP) begin
          mdl_applied = f;
          mdl_index   = gamma_index_for(f);
        end
      end else if (f <= reg_low_bat) begin
        mdl_lowbat = 1'b1;
      end
      // shutdown write: power, start and channel all zero
      r.wr = 1'b1;
      mdl_delay = (reg_delay < DELAY_MIN) ? DELAY_MIN : reg_delay;
      mdl_chan  = reg_bl_en ? ~ch : CH_BAT;
    end
    // icon blink: sent every 512 ticks, shown on even periods, hidden on odd
    if (mdl_lowbat && reg_icon_en && (mdl_tick & BLINK_MASK) == '0) begin
      r.bat_upd  = 1'b1;
      r.bat_show = (mdl_tick & BLINK_PHASE) == '0;
    end
    mdl_tick  = mdl_tick + 16'd1;
    r.idx     = mdl_index;
    r.bl_upd  = mdl_index != prev_idx;
    r.low_bat = mdl_lowbat;
    return r;
  endfunction

  // ---------------------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------------------
  function automatic void compare_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      n_errors++;
    end
  endfunction

  function automatic void check_result(adc_result_t want, adc_result_t got);
    compare_field("adc_ctrl_write", want.wr, got.wr);
    compare_field("adc_power", want.pwr, got.pwr);
    compare_field("adc_start", want.start, got.start);
    compare_field("adc_channel_sel", want.chan, got.chan);
    compare_field("backlight_index", want.idx, got.idx);
    compare_field("backlight_update", want.bl_upd, got.bl_upd);
    compare_field("battery_update", want.bat_upd, got.bat_upd);
    compare_field("battery_show", want.bat_show, got.bat_show);
    compare_field("low_battery", want.low_bat, got.low_bat);
  endfunction

  // ---------------------------------------------------------------------------------------
  // Driver: takes ticks from pending_ticks; the model advances when the item is accepted.
  // Valid holds with a stable payload until accepted.
  // ---------------------------------------------------------------------------------------
  always @(posedge clk) begin : tick_driver
    if (!rst_n) begin
      in_valid      <= 1'b0;
      in_adc_done   <= 1'b0;
      in_adc_sample <= '0;
    end else begin
      if (in_valid && in_ready)
        expected_results.push_back(advance_tick(cur_tick));
      if (!in_valid || in_ready) begin
        if (pending_ticks.size() != 0 && $urandom_range(99) >= idle_pct) begin
          cur_tick       = pending_ticks.pop_front();
          in_valid      <= 1'b1;
          in_adc_done   <= cur_tick.done;
          in_adc_sample <= cur_tick.sample;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Monitor: every accepted result is matched against the oldest prediction
  // ---------------------------------------------------------------------------------------
  always @(posedge clk) begin : result_monitor
    adc_result_t got;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got = {out_adc_ctrl_write, out_adc_power, out_adc_start, out_adc_channel_sel,
               out_backlight_index, out_backlight_update, out_battery_update,
               out_battery_show, out_low_battery};
        if (expected_results.size() == 0) begin
          $display("%0t: result item with none expected: %h", $time, got);
          n_errors++;
        end else begin
          check_result(expected_results.pop_front(), got);
        end
        n_checked++;
      end
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // ---------------------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------------------
  task automatic queue_tick(tick_in_t t);
    pending_ticks.push_back(t);
    n_queued++;
  endtask

  // mostly random samples, with the rails mixed in; done set often enough that
  // the sequencer cycles through all of its steps
  function automatic tick_in_t random_tick();
    tick_in_t t;
    t.done = ($urandom_range(99) < 40);
    case ($urandom_range(9))
      0:       t.sample = 16'h0000;
      1:       t.sample = 16'hFFFF;
      default: t.sample = 16'($urandom);
    endcase
    return t;
  endfunction

  // wait until every queued tick has produced its result, then let the block settle
  task automatic wait_drained();
    while (n_checked != n_queued) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t r, logic [15:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= r;
    cfg_data  <= v;
    case (r)
      CFG_BL_RAW_LOW:    reg_bl_lo   = v;
      CFG_BL_RAW_HIGH:   reg_bl_hi   = v;
      CFG_LOW_BAT_LEVEL: reg_low_bat = v;
      CFG_MEAS_DELAY:    reg_delay   = v[7:0];
      CFG_BAT_ICON_EN:   reg_icon_en = v[0];
      CFG_BL_EN:         reg_bl_en   = v[0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // reconfigure while idle, then run a block of random ticks under one idling mode
  task automatic run_phase(logic [15:0] lo, logic [15:0] hi, logic [15:0] bat_lvl,
                           logic [7:0] delay, logic icon, logic bl, int n_ticks,
                           int gap_pct, int hold_pct);
    wait_drained();
    write_reg(CFG_BL_RAW_LOW, lo);
    write_reg(CFG_BL_RAW_HIGH, hi);
    write_reg(CFG_LOW_BAT_LEVEL, bat_lvl);
    write_reg(CFG_MEAS_DELAY, {8'd0, delay});
    write_reg(CFG_BAT_ICON_EN, {15'd0, icon});
    write_reg(CFG_BL_EN, {15'd0, bl});
    idle_pct  = gap_pct;
    stall_pct = hold_pct;
    for (int i = 0; i < n_ticks; i++) queue_tick(random_tick());
  endtask

  initial begin : main_seq
    tick_in_t t;
    reset_model();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed, at reset settings: done flags and rail samples during the first
    // countdown (ignored), a wait tick without done, a battery sample at full scale
    // (keeps the battery filter high), then a full-scale knob sample that picks
    // the first index, and on into the next countdown.
    for (int i = 0; i < 24; i++) begin
      t.done   = (i < 9) ? i[0] : (i == 10 || i == 21);
      t.sample = (i == 10 || i == 21 || i[0]) ? 16'hFFFF : 16'h0000;
      if (i == 9) t.sample = 16'h8001;
      queue_tick(t);
    end

    // battery level 0: no latch while the knob settings are swept
    run_phase(16'h1000, 16'hF000, 16'h0000, 8'd2,   1'b1, 1'b1, 100,  0,  0);
    // full knob span, delay below two, icon off
    run_phase(16'h0000, 16'hFFFF, 16'h0000, 8'd1,   1'b0, 1'b1, 100, 50,  0);
    // knob span under one step: divisor forced to one; delay zero
    run_phase(16'h8000, 16'h80FF, 16'h0000, 8'd0,   1'b1, 1'b1, 100,  0, 50);
    // inverted knob span
    run_phase(16'hC000, 16'h4000, 16'h0000, 8'd3,   1'b1, 1'b1, 100, 28, 28);
    // backlight off: battery only (a knob measurement in progress still completes)
    run_phase(16'hFFFF, 16'h0000, 16'h8000, 8'd5,   1'b1, 1'b0, 100,  0,  0);
    // battery level at the top: latches on the first battery sample
    run_phase(16'h1000, 16'hF000, 16'hFFFF, 8'd2,   1'b1, 1'b1, 200, 50,  0);
    // longest delay
    run_phase(16'h2000, 16'h3000, 16'hFFFF, 8'd255, 1'b1, 1'b1, 200,  0, 50);
    // latched but icon disabled
    run_phase(16'h1000, 16'hF000, 16'hFFFF, 8'd2,   1'b0, 1'b1, 100, 28, 28);
    // back to the reset register values
    run_phase(BL_RAW_LOW_RST, BL_RAW_HIGH_RST, LOW_BAT_LEVEL_RST, MEAS_DELAY_RST,
              1'b1, 1'b1, 100, 0, 0);

    wait_drained();
    if (n_errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // hang guard: the slowest correct run is well under a tenth of this
  initial begin : hang_guard
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
